### hdl/lsar_pkg.sv
// lsar_pkg: shared types, constants and the integration-time table
// for the light sensor auto-ranging reporter; no dependencies
package lsar_pkg;

	// item kinds as classified by the front end
	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} lsar_op_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLL_DELAY = 1'b0,
		REG_RESOLUTION = 1'b1
	} lsar_reg_t;

	// queued word between front and back
	typedef struct packed {
		lsar_op_t    op;
		logic [15:0] raw_count;
		logic [31:0] now_ms;
	} lsar_item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic       valid;
		lsar_item_t item;
	} lsar_head_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [4:0]  TBL_LAST      = 5'd22;
	localparam logic [15:0] SAT_COUNT     = 16'hFFFF;
	localparam logic [20:0] LOW_LUX       = 21'd10;
	localparam logic [4:0]  HW_DELAY_MS   = 5'd10;
	localparam logic [15:0] POLL_MIN_MS   = 16'd43;
	localparam logic [15:0] POLL_RESET_MS = 16'd1600;
	localparam logic [7:0]  CMD1_BASE     = 8'h22;

	// divide by 10000 as (p >> 4) / 625, with floor(2^40 / 625) as reciprocal
	localparam int          DIV_PRE_SHIFT = 4;
	localparam int          RECIP_SHIFT   = 40;
	localparam logic [30:0] RECIP_625     = 31'd1759218604;
	localparam logic [9:0]  DIV_625       = 10'd625;

	typedef struct packed {
		logic [11:0] ms;
		logic [2:0]  fd_it;
		logic [1:0]  it_t;
		logic [17:0] mult;   // 6000000 / ms
	} lsar_it_t;

	// integration table, position 0 is the longest time
	function automatic lsar_it_t lsar_it_entry(input logic [4:0] pos);
		lsar_it_t e;
		case (pos)
			5'd0:    e = '{12'd3200, 3'd0, 2'd3, 18'd1875};
			5'd1:    e = '{12'd1600, 3'd0, 2'd2, 18'd3750};
			5'd2:    e = '{12'd1064, 3'd2, 2'd3, 18'd5639};
			5'd3:    e = '{12'd800,  3'd0, 2'd1, 18'd7500};
			5'd4:    e = '{12'd532,  3'd2, 2'd2, 18'd11278};
			5'd5:    e = '{12'd520,  3'd4, 2'd3, 18'd11538};
			5'd6:    e = '{12'd400,  3'd1, 2'd1, 18'd15000};
			5'd7:    e = '{12'd320,  3'd6, 2'd3, 18'd18750};
			5'd8:    e = '{12'd266,  3'd2, 2'd1, 18'd22556};
			5'd9:    e = '{12'd264,  3'd7, 2'd3, 18'd22727};
			5'd10:   e = '{12'd260,  3'd4, 2'd2, 18'd23076};
			5'd11:   e = '{12'd200,  3'd3, 2'd1, 18'd30000};
			5'd12:   e = '{12'd160,  3'd6, 2'd2, 18'd37500};
			5'd13:   e = '{12'd133,  3'd2, 2'd0, 18'd45112};
			5'd14:   e = '{12'd132,  3'd7, 2'd2, 18'd45454};
			5'd15:   e = '{12'd130,  3'd4, 2'd1, 18'd46153};
			5'd16:   e = '{12'd100,  3'd5, 2'd1, 18'd60000};
			5'd17:   e = '{12'd80,   3'd6, 2'd1, 18'd75000};
			5'd18:   e = '{12'd66,   3'd7, 2'd1, 18'd90909};
			5'd19:   e = '{12'd65,   3'd4, 2'd0, 18'd92307};
			5'd20:   e = '{12'd50,   3'd5, 2'd0, 18'd120000};
			5'd21:   e = '{12'd40,   3'd6, 2'd0, 18'd150000};
			default: e = '{12'd33,   3'd7, 2'd0, 18'd181818};
		endcase
		return e;
	endfunction

	// requeue delay for integration time ms when not resyncing
	function automatic logic [15:0] lsar_requeue(input logic [11:0] ms, input logic [15:0] poll);
		logic [16:0] sum;
		sum = {5'd0, ms} + {12'd0, HW_DELAY_MS};
		return (sum < {1'b0, poll}) ? poll : sum[15:0];
	endfunction

endpackage

### hdl/lsar_front.sv
// lsar_front: input handshake, item classification and the short queue
// toward the back end; depends on lsar_pkg
module lsar_front import lsar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] raw_count,
	input  logic [31:0] now_ms,
	output lsar_head_t  head,
	input  logic        pop
);

	lsar_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                do_pop;
	lsar_item_t          item_in;

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (count_q != '0);

	always_comb begin
		item_in.op        = mode ? OP_START : OP_SAMPLE;
		item_in.raw_count = raw_count;
		item_in.now_ms    = now_ms;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(QDEPTH)) && !pop |=> (count_q == QCNT_W'(QDEPTH)))
		else $error("queue lost a word while full");

endmodule

### hdl/lsar_back.sv
// lsar_back: lux arithmetic, range stepping, report decision, config
// registers and the result register; depends on lsar_pkg
module lsar_back import lsar_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsar_head_t           head,
	output logic                 pop,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 lux_valid,
	output logic [20:0]          lux_value,
	output logic                 cmd_valid,
	output logic [7:0]           cmd_first,
	output logic [7:0]           cmd_second,
	output logic [15:0]          requeue_ms,
	output logic [4:0]           range_index
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECIP,
		ST_FIX,
		ST_DONE
	} back_st_t;

	back_st_t       st_q;
	lsar_item_t     item_q;
	logic [33:0]    prod_q;
	logic [60:0]    recip_q;
	logic [20:0]    q0_q;
	logic [30:0]    t_q;

	// block state
	logic [15:0]          poll_q;
	logic [15:0]          res_q;
	logic [4:0]           pos_q;
	logic                 drop_q;
	logic                 resync_q;
	logic                 first_q;
	logic                 started_q;
	logic [20:0]          last_lux_q;
	logic [TIME_BITS-1:0] last_time_q;
	logic [15:0]          requeue_q;

	// result register
	logic        out_valid_q;
	logic        lux_valid_q;
	logic [20:0] lux_value_q;
	logic        cmd_valid_q;
	logic [7:0]  cmd_first_q;
	logic [7:0]  cmd_second_q;

	// next-state terms of the commit cycle
	logic                 commit;
	logic [29:0]          x_w;
	logic [30:0]          r_w;
	logic [20:0]          lux_w;
	logic [4:0]           start_pos;
	lsar_it_t             cur_e;
	lsar_it_t             step_e;
	logic                 step;
	logic [4:0]           step_pos;
	logic                 report;
	logic                 win_out;
	logic [20:0]          last_mid;
	logic [14:0]          half;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 n_drop;
	logic                 n_resync;
	logic                 n_first;
	logic                 n_started;
	logic [4:0]           n_pos;
	logic [15:0]          n_requeue;
	logic [20:0]          n_last_lux;
	logic [TIME_BITS-1:0] n_last_time;
	logic [15:0]          poll_wr;
	logic                 skip;

	assign pop    = (st_q == ST_IDLE) && head.valid;
	assign commit = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	assign cur_e  = lsar_it_entry(pos_q);
	assign skip   = !started_q || drop_q;

	// start picks the longest time not above the poll delay
	always_comb begin
		start_pos = TBL_LAST;
		for (int k = 22; k >= 0; k--) begin
			if (poll_q >= {4'd0, lsar_it_entry(5'(k)).ms}) begin
				start_pos = 5'(k);
			end
		end
	end

	always_comb begin
		x_w   = prod_q[33:DIV_PRE_SHIFT];
		r_w   = {1'b0, x_w} - t_q;
		lux_w = q0_q + 21'(r_w >= {21'd0, DIV_625});
		now_t = TIME_BITS'(item_q.now_ms);

		n_drop      = drop_q;
		n_resync    = resync_q;
		n_first     = first_q;
		n_started   = started_q;
		n_pos       = pos_q;
		n_requeue   = requeue_q;
		n_last_lux  = last_lux_q;
		n_last_time = last_time_q;
		step        = 1'b0;
		step_pos    = pos_q;
		report      = 1'b0;

		if (item_q.op == OP_START) begin
			step      = 1'b1;
			step_pos  = start_pos;
			n_started = 1'b1;
			n_first   = 1'b1;
		end else if (skip) begin
			n_drop = 1'b0;
		end else if ((item_q.raw_count == SAT_COUNT) && (pos_q < TBL_LAST)) begin
			step     = 1'b1;
			step_pos = pos_q + 5'd1;
		end else if ((lux_w <= LOW_LUX) && (pos_q != 5'd0)) begin
			step     = 1'b1;
			step_pos = pos_q - 5'd1;
		end else if (resync_q) begin
			n_resync  = 1'b0;
			n_requeue = lsar_requeue(cur_e.ms, poll_q);
		end

		step_e = lsar_it_entry(step_pos);
		if (step) begin
			n_drop     = 1'b1;
			n_pos      = step_pos;
			n_resync   = 1'b1;
			n_last_lux = '0;
			n_requeue  = 16'({5'd0, step_e.ms} + {12'd0, HW_DELAY_MS});
		end

		// window around the last report, after any step cleared it
		last_mid = step ? 21'd0 : last_lux_q;
		half     = res_q[15:1];
		win_out  = (res_q == '0) ||
			({1'b0, lux_w} > ({1'b0, last_mid} + {7'd0, half})) ||
			(({1'b0, lux_w} + {7'd0, half}) < {1'b0, last_mid});
		elapsed  = first_q ? '0 : (now_t - last_time_q);

		if ((item_q.op == OP_SAMPLE) && !skip &&
			(first_q || (win_out && (elapsed >= TIME_BITS'(poll_q))))) begin
			report      = 1'b1;
			n_last_lux  = lux_w;
			n_last_time = now_t;
			n_first     = 1'b0;
		end

		poll_wr = (cfg_data < POLL_MIN_MS) ? POLL_MIN_MS : cfg_data;
	end

	// sequencer and arithmetic registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (head.valid) begin
						st_q <= ((head.item.op == OP_START) || skip) ? ST_DONE : ST_RECIP;
					end
				end
				ST_RECIP: st_q <= ST_FIX;
				ST_FIX:   st_q <= ST_DONE;
				ST_DONE: begin
					if (commit) begin
						st_q <= ST_IDLE;
					end
				end
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
			prod_q <= {18'd0, head.item.raw_count} * {16'd0, cur_e.mult};
		end
		if (st_q == ST_RECIP) begin
			recip_q <= {31'd0, x_w} * {30'd0, RECIP_625};
		end
		if (st_q == ST_FIX) begin
			q0_q <= recip_q[60:RECIP_SHIFT];
			t_q  <= {10'd0, recip_q[60:RECIP_SHIFT]} * {21'd0, DIV_625};
		end
	end

	// block state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q      <= POLL_RESET_MS;
			res_q       <= '0;
			pos_q       <= '0;
			drop_q      <= 1'b0;
			resync_q    <= 1'b0;
			first_q     <= 1'b0;
			started_q   <= 1'b0;
			last_lux_q  <= '0;
			last_time_q <= '0;
			requeue_q   <= '0;
		end else begin
			if (commit) begin
				pos_q       <= n_pos;
				drop_q      <= n_drop;
				resync_q    <= n_resync;
				first_q     <= n_first;
				started_q   <= n_started;
				last_lux_q  <= n_last_lux;
				last_time_q <= n_last_time;
				requeue_q   <= n_requeue;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_POLL_DELAY: begin
						if (poll_wr != poll_q) begin
							poll_q    <= poll_wr;
							requeue_q <= lsar_requeue(cur_e.ms, poll_wr);
						end
					end
					REG_RESOLUTION: res_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			lux_valid_q  <= report;
			lux_value_q  <= report ? lux_w : 21'd0;
			cmd_valid_q  <= step;
			cmd_first_q  <= step ? (CMD1_BASE | {4'd0, step_e.it_t, 2'd0}) : 8'd0;
			cmd_second_q <= step ? {step_e.fd_it, 5'd0} : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign lux_valid   = lux_valid_q;
	assign lux_value   = lux_value_q;
	assign cmd_valid   = cmd_valid_q;
	assign cmd_first   = cmd_first_q;
	assign cmd_second  = cmd_second_q;
	assign requeue_ms  = requeue_q;
	assign range_index = pos_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= TBL_LAST)
		else $error("table position beyond last entry");

	a_poll_floor: assert property (@(posedge clk) disable iff (!arst_n)
		poll_q >= POLL_MIN_MS)
		else $error("poll delay below floor");

	a_cmd_arms_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cmd_valid_q |-> drop_q && resync_q)
		else $error("command word without drop and resync armed");

	a_report_clears_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && lux_valid_q |-> !first_q)
		else $error("report left first flag set");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && (st_q == ST_IDLE))
		else $error("committed word not shown");

endmodule

### hdl/light_sensor_autorange_reporter_core.sv
// light_sensor_autorange_reporter_core: top level of the auto-ranging
// light reporter; depends on lsar_pkg, lsar_front, lsar_back
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   input   | in_valid/in_ready, mode, raw_count, now_ms      | in
//   result  | out_valid/out_ready, lux_valid, lux_value,      | out
//           | cmd_valid, cmd_first, cmd_second, requeue_ms,   |
//           | range_index                                     |
//   config  | cfg_wr_en, cfg_index, cfg_data (no read-back)   | in
//
// a sample word passes the back end in order: pop plus 16x18 multiply,
// reciprocal multiply for the divide by 10000, remainder fix-up, commit;
// start and dropped words go from pop straight to commit
// the two-entry queue accepts words while not full, also while the back
// end works or its result word waits; a stalled result holds the back end in commit
// reset clears all control and block state, poll delay resets to 1600 ms
module light_sensor_autorange_reporter_core import lsar_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [15:0]          raw_count,
	input  logic [31:0]          now_ms,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 lux_valid,
	output logic [20:0]          lux_value,
	output logic                 cmd_valid,
	output logic [7:0]           cmd_first,
	output logic [7:0]           cmd_second,
	output logic [15:0]          requeue_ms,
	output logic [4:0]           range_index,
	// register writes
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// queue head handed to the back end, and its pop strobe
	lsar_head_t head;
	logic       pop;

	// front: accept, tag start vs sample, queue
	lsar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.raw_count (raw_count),
		.now_ms    (now_ms),
		.head      (head),
		.pop       (pop)
	);

	// back: lux math, ranging, reporting, registers, result word
	lsar_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.lux_valid   (lux_valid),
		.lux_value   (lux_value),
		.cmd_valid   (cmd_valid),
		.cmd_first   (cmd_first),
		.cmd_second  (cmd_second),
		.requeue_ms  (requeue_ms),
		.range_index (range_index)
	);

endmodule
